// ----- src/bti_pkg.sv -----
// Package for the bilinear table interpolator.
// Holds request codes, sequencer states, shared widths and APB register addresses; no dependencies.
package bti_pkg;

  typedef enum logic [1:0] {
    REQ_ROW_BRK = 2'd0,
    REQ_COL_BRK = 2'd1,
    REQ_CELL    = 2'd2,
    REQ_LOOKUP  = 2'd3
  } req_e;

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_SEARCH = 10'b0000000010,
    ST_DIV    = 10'b0000000100,
    ST_WGT    = 10'b0000001000,
    ST_RD     = 10'b0000010000,
    ST_MAC    = 10'b0000100000,
    ST_MACH   = 10'b0001000000,
    ST_RND    = 10'b0010000000,
    ST_OUT    = 10'b0100000000,
    ST_FAIL   = 10'b1000000000
  } state_e;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CNT_W  = 5;
  localparam int unsigned ADDR_W = 3;

  localparam logic [ADDR_W-1:0] ADDR_ROW_COUNT = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_COL_COUNT = 3'd4;

endpackage

// ----- src/bilinear_table_interpolator.sv -----
// Top level of the bilinear table interpolator.
// Uses bti_pkg; one shared divider, one 32 x (FRAC_BITS+1) multiplier under a sequencer.
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid_i/stall_o | req_type, indices, value, queries
//  out     | output    | out_valid_o/stall_i| interp_value, in_range
//  cfg     | input     | APB psel/penable   | row_count, col_count
//
// Writes may follow back to back. A lookup scans each axis's breakpoints (a read, then
// a compare per breakpoint), runs a (33+FRAC_BITS)-step restoring division per axis,
// then forms the products of the four corner weights and cells, rounds and outputs.
// Reset clears counts and control; the tables are undefined until written.
// The input stalls only while a lookup runs; a stalled result holds the next lookup.
module bilinear_table_interpolator #(
  parameter int unsigned ROW_MAX   = 16,
  parameter int unsigned COL_MAX   = 16,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         req_type_i,
  input  logic [3:0]                         row_index_i,
  input  logic [3:0]                         col_index_i,
  input  logic signed [bti_pkg::DATA_W-1:0]  write_value_i,
  input  logic signed [bti_pkg::DATA_W-1:0]  row_query_i,
  input  logic signed [bti_pkg::DATA_W-1:0]  col_query_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [bti_pkg::DATA_W-1:0]  interp_value_o,
  output logic                               in_range_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [bti_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int unsigned RW = (ROW_MAX > 1) ? $clog2(ROW_MAX) : 1;
  localparam int unsigned CW = (COL_MAX > 1) ? $clog2(COL_MAX) : 1;
  localparam int unsigned GD = ROW_MAX * COL_MAX;
  localparam int unsigned GW = RW + CW;
  localparam int unsigned WW = FRAC_BITS + 1;          // weight incl. ONE
  localparam int unsigned NW = 33 + FRAC_BITS;         // dividend width
  localparam int unsigned BW = $clog2(NW + 1);
  localparam int unsigned AW = 32 + WW + 3;            // accumulator
  localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

  bti_pkg::state_e state_q;

  logic signed [31:0] row_mem [ROW_MAX];
  logic signed [31:0] col_mem [COL_MAX];
  logic signed [31:0] grid_mem [GD];

  logic [bti_pkg::CNT_W-1:0] row_cnt_q, col_cnt_q;
  logic signed [31:0] qr_q, qc_q, q_cur, brk_rd_q, brk_prev_q, brk_first_q;
  logic axis_q;                      // 0 row, 1 column
  logic [8:0] idx_q;                 // scan position, wide enough for 256
  logic found_q;
  logic [RW-1:0] ri_q;
  logic [CW-1:0] ci_q;
  logic [NW-1:0] num_q, quo_q;
  logic [33:0] den_q, rem_q;
  logic [BW-1:0] bit_q;
  logic [WW-1:0] wr_q, wc_q;
  logic [1:0] corner_q;
  logic [WW-1:0] w_q;
  logic signed [31:0] cell_q;
  logic signed [AW-1:0] acc_q;
  logic [1:0] phase_q;
  logic signed [31:0] res_q;
  logic rng_q, ovalid_q;

  // APB
  assign pready = 1'b1;
  always_comb begin
    case (paddr)
      bti_pkg::ADDR_ROW_COUNT: prdata = 32'(row_cnt_q);
      bti_pkg::ADDR_COL_COUNT: prdata = 32'(col_cnt_q);
      default:                 prdata = '0;
    endcase
  end

  logic [8:0] rcnt, ccnt, n_cur;
  always_comb begin
    rcnt = (9'(row_cnt_q) > 9'(ROW_MAX)) ? 9'(ROW_MAX) : 9'(row_cnt_q);
    ccnt = (9'(col_cnt_q) > 9'(COL_MAX)) ? 9'(COL_MAX) : 9'(col_cnt_q);
    n_cur = axis_q ? ccnt : rcnt;
    q_cur = axis_q ? qc_q : qr_q;
  end

  wire in_acc  = in_valid_i && !in_stall_o;
  wire out_acc = ovalid_q && !out_stall_i;
  // load the output register once the previous result has left
  wire res_load = ((state_q == bti_pkg::ST_OUT) || (state_q == bti_pkg::ST_FAIL))
                  && (!ovalid_q || !out_stall_i);
  assign in_stall_o = (state_q != bti_pkg::ST_IDLE);

  // shared multiplier: signed 32 x unsigned WW
  logic signed [31:0] mul_a;
  logic [WW-1:0] mul_b;
  logic signed [32+WW:0] mul_p;
  assign mul_p = mul_a * $signed({1'b0, mul_b});

  logic [33:0] rem_sh;
  logic [34:0] rem_try;
  assign rem_sh  = {rem_q[32:0], num_q[NW-1]};
  assign rem_try = {1'b0, rem_sh} - {1'b0, den_q};

  logic [WW-1:0] fr, fc;
  always_comb begin
    fr = corner_q[0] ? wr_q : ONE - wr_q;
    fc = corner_q[1] ? wc_q : ONE - wc_q;
    mul_a = 32'sd0;
    mul_b = '0;
    if (state_q == bti_pkg::ST_WGT) begin
      mul_a = $signed(32'(fr));
      mul_b = fc;
    end else begin
      mul_a = cell_q;
      mul_b = w_q;
    end
  end

  // tables
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      case (req_type_i)
        bti_pkg::REQ_ROW_BRK:
          if (32'(row_index_i) < ROW_MAX) row_mem[RW'(row_index_i)] <= write_value_i;
        bti_pkg::REQ_COL_BRK:
          if (32'(col_index_i) < COL_MAX) col_mem[CW'(col_index_i)] <= write_value_i;
        bti_pkg::REQ_CELL:
          if (32'(row_index_i) < ROW_MAX && 32'(col_index_i) < COL_MAX)
            grid_mem[GW'(32'(row_index_i) * COL_MAX + 32'(col_index_i))] <= write_value_i;
        default: ;
      endcase
    end
    // registered breakpoint read for the scan
    if (axis_q) brk_rd_q <= col_mem[CW'(idx_q)];
    else        brk_rd_q <= row_mem[RW'(idx_q)];
    cell_q <= grid_mem[GW'(32'(ri_q + RW'(corner_q[0])) * COL_MAX
                          + 32'(ci_q + CW'(corner_q[1])))];
  end

  logic signed [32:0] q_ext, lo_ext, hi_ext;
  assign q_ext  = 33'(q_cur);
  assign lo_ext = 33'(brk_prev_q);
  assign hi_ext = 33'(brk_rd_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bti_pkg::ST_IDLE;
      row_cnt_q <= '0;
      col_cnt_q <= '0;
      ovalid_q  <= 1'b0;
      axis_q    <= 1'b0;
      idx_q     <= '0;
      found_q   <= 1'b0;
      bit_q     <= '0;
      corner_q  <= '0;
      phase_q   <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr)
          bti_pkg::ADDR_ROW_COUNT: row_cnt_q <= pwdata[bti_pkg::CNT_W-1:0];
          bti_pkg::ADDR_COL_COUNT: col_cnt_q <= pwdata[bti_pkg::CNT_W-1:0];
          default: ;
        endcase
      end
      if (res_load)     ovalid_q <= 1'b1;
      else if (out_acc) ovalid_q <= 1'b0;
      case (state_q)
        bti_pkg::ST_IDLE: begin
          axis_q  <= 1'b0;
          idx_q   <= '0;
          found_q <= 1'b0;
          phase_q <= '0;
          if (in_acc && req_type_i == bti_pkg::REQ_LOOKUP) state_q <= bti_pkg::ST_SEARCH;
        end
        bti_pkg::ST_SEARCH: begin
          // phase 0: issue read; phase 1: data valid
          if (n_cur < 9'd2) begin
            state_q <= bti_pkg::ST_FAIL;
          end else if (phase_q == 2'd0) begin
            phase_q <= 2'd1;
          end else begin
            phase_q <= 2'd0;
            if (idx_q == 9'd0) begin
              brk_first_q <= brk_rd_q;
            end else if (!found_q && q_ext >= lo_ext && q_ext < hi_ext) begin
              found_q <= 1'b1;
              if (axis_q) ci_q <= CW'(idx_q - 9'd1);
              else        ri_q <= RW'(idx_q - 9'd1);
              num_q <= NW'(q_ext - lo_ext) << FRAC_BITS;
              den_q <= 34'(hi_ext - lo_ext);
            end
            brk_prev_q <= brk_rd_q;
            if (idx_q == n_cur - 9'd1) begin
              // last breakpoint: check span then divide
              if ((found_q || (q_ext >= lo_ext && q_ext < hi_ext))
                  && q_ext >= 33'(brk_first_q) && q_ext < hi_ext) begin
                state_q <= bti_pkg::ST_DIV;
                bit_q   <= BW'(NW);
                rem_q   <= '0;
              end else begin
                state_q <= bti_pkg::ST_FAIL;
              end
            end else begin
              idx_q <= idx_q + 9'd1;
            end
          end
        end
        bti_pkg::ST_DIV: begin
          if (bit_q != '0) begin
            num_q <= {num_q[NW-2:0], ~rem_try[34]};
            rem_q <= rem_try[34] ? rem_sh : rem_try[33:0];
            bit_q <= bit_q - BW'(1);
          end else begin
            if (axis_q) begin
              wc_q     <= WW'(num_q);
              state_q  <= bti_pkg::ST_WGT;
              corner_q <= '0;
              acc_q    <= '0;
            end else begin
              wr_q    <= WW'(num_q);
              axis_q  <= 1'b1;
              idx_q   <= '0;
              found_q <= 1'b0;
              state_q <= bti_pkg::ST_SEARCH;
            end
          end
        end
        bti_pkg::ST_WGT: begin
          w_q     <= WW'(mul_p[32+WW:0] >>> FRAC_BITS);
          state_q <= bti_pkg::ST_RD;
        end
        bti_pkg::ST_RD: state_q <= bti_pkg::ST_MAC;
        bti_pkg::ST_MAC: begin
          acc_q <= acc_q + AW'(mul_p);
          if (corner_q == 2'd3) begin
            state_q <= bti_pkg::ST_RND;
          end else begin
            corner_q <= corner_q + 2'd1;
            state_q  <= bti_pkg::ST_WGT;
          end
        end
        bti_pkg::ST_MACH: state_q <= bti_pkg::ST_IDLE;
        bti_pkg::ST_RND: begin
          acc_q   <= (acc_q + (AW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
          state_q <= bti_pkg::ST_OUT;
        end
        bti_pkg::ST_OUT: begin
          if (res_load) begin
            if (acc_q > AW'(32'sh7fffffff))       res_q <= 32'sh7fffffff;
            else if (acc_q < -AW'(33'sh080000000)) res_q <= 32'sh80000000;
            else                                   res_q <= acc_q[31:0];
            rng_q   <= 1'b1;
            state_q <= bti_pkg::ST_IDLE;
          end
        end
        bti_pkg::ST_FAIL: begin
          if (res_load) begin
            res_q   <= '0;
            rng_q   <= 1'b0;
            state_q <= bti_pkg::ST_IDLE;
          end
        end
        default: state_q <= bti_pkg::ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      qr_q <= row_query_i;
      qc_q <= col_query_i;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign interp_value_o = res_q;
  assign in_range_o     = rng_q;

endmodule

// ----- src/bti_checker.sv -----
// Port-level checker for the bilinear table interpolator, with its bind.
// Depends on bilinear_table_interpolator ports only.
module bti_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  req_type_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] interp_value_o,
  input logic        in_range_o
);
  // hold result while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(interp_value_o))
    else $error("result changed under stall");
  // out of range reads zero
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !in_range_o |-> interp_value_o == 32'd0)
    else $error("nonzero value out of range");
  // hold the range flag while stalled
  a_rng: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(in_range_o))
    else $error("range flag changed under stall");
  // a lookup blocks the input next cycle
  a_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == 2'd3 |=> in_stall_o)
    else $error("lookup did not block input");
endmodule

bind bilinear_table_interpolator bti_checker u_bti_checker (.*);
